[hdl/wal_pkg.sv]
// Package for the windowed acceleration limiter.
// Holds the request and result structs, lane control structs, codes and constants.
// It depends on nothing else and is used by every module in the block.
package wal_pkg;

  // Default number of history entries per axis.
  localparam int WINDOW_DEPTH_DEF = 16;

  // Q1.15 value of one.
  localparam logic [15:0] ONE_Q15 = 16'd32768;

  // Raw Q4.12 value of 0.02: at or below it the x step is halved.
  localparam logic signed [15:0] SLOW_X_RAW = 16'sd81;

  // Number of quotient bits the lane divider produces.
  localparam int DIV_STEPS = 16;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    CFG_MAX_ACC_X   = 3'd0,
    CFG_MAX_ACC_Y   = 3'd1,
    CFG_MAX_ACC_ROT = 3'd2,
    CFG_WINDOW_X    = 3'd3,
    CFG_WINDOW_Y    = 3'd4,
    CFG_WINDOW_ROT  = 3'd5
  } wal_cfg_idx_t;

  // One input request.
  typedef struct packed {
    logic        [31:0] tick_time;
    logic signed [15:0] meas_x;
    logic signed [15:0] meas_y;
    logic signed [15:0] meas_rot;
    logic signed [15:0] current_x;
    logic signed [15:0] want_x;
    logic signed [15:0] want_y;
    logic signed [15:0] want_rot;
  } wal_in_t;

  // One result.
  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_rot;
    logic        [15:0] scale;
  } wal_out_t;

  // Commands from the top level to one lane.
  typedef struct packed {
    logic check;
    logic update;
    logic restart_pre;
    logic restart_post;
  } wal_lane_cmd_t;

  // Status from one lane to the top level.
  typedef struct packed {
    logic        busy;
    logic        stale;
    logic [15:0] factor;
  } wal_lane_stat_t;

  // Magnitude of a signed 16-bit speed, widened so that -32768 fits.
  function automatic logic [16:0] mag16(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = {v[15], v};
    mag16 = v[15] ? 17'(-e) : 17'(e);
  endfunction

endpackage

[hdl/wal_lane.sv]
// One axis lane of the windowed acceleration limiter.
// Holds the timestamped speed history in a memory, ages it, scans for the
// reference speed and divides out the limiting factor. Depends on wal_pkg.
module wal_lane #(
  parameter int WINDOW_DEPTH = wal_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  wal_pkg::wal_lane_cmd_t    cmd,
  input  logic               [31:0] now,
  input  logic signed        [15:0] meas,
  input  logic signed        [15:0] want,
  input  logic               [15:0] acc2,
  input  logic               [15:0] win,
  output wal_pkg::wal_lane_stat_t   stat
);

  localparam int IW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [3:0] {
    L_IDLE, L_CK_H, L_CK_T, L_CK_E, L_WAIT, L_AG_R, L_AG_C, L_FULL,
    L_WR, L_SCAN, L_SEND, L_LIM, L_DIV, L_DONE
  } lane_state_t;

  lane_state_t state;

  // History store and its registered read port.
  logic        [31:0] mem_t [WINDOW_DEPTH];
  logic signed [15:0] mem_v [WINDOW_DEPTH];
  logic        [IW-1:0] rd_addr;
  logic        [31:0] rd_t;
  logic signed [15:0] rd_v;
  logic               rd_zero;
  logic        [31:0] rt;
  logic signed [15:0] rv;

  // Window bookkeeping.
  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic          zflag;
  logic [31:0]   t_head;
  logic [31:0]   t_tail;
  logic          stale;

  // Latched request fields.
  logic        [31:0] now_r;
  logic signed [15:0] meas_r;
  logic signed [15:0] want_r;
  logic        [15:0] acc2_r;
  logic        [15:0] win_r;
  logic               rpost;

  // Scan and divide state.
  logic [CW-1:0]      idx;
  logic               sc_v;
  logic signed [15:0] ref_v;
  logic               ref_first;
  logic [16:0]        rem;
  logic [15:0]        nlo;
  logic [15:0]        quo;
  logic [16:0]        dv;
  logic [4:0]         dcnt;
  logic [15:0]        factor;

  // Combinational helpers.
  logic [IW-1:0] tail_old;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] scan_addr;
  logic [IW-1:0] head_inc;
  logic [16:0]   mw;
  logic [16:0]   mr;
  logic [16:0]   mr2;
  logic          nolim;
  logic [17:0]   target2;
  logic [17:0]   sh;
  logic          qbit;
  logic          aged;

  // Sum of an index and an offset, folded back into the store.
  function automatic logic [IW-1:0] wrap(input logic [CW:0] s);
    wrap = (s >= (CW+1)'(WINDOW_DEPTH)) ? IW'(s - (CW+1)'(WINDOW_DEPTH)) : IW'(s);
  endfunction

  assign tail_old  = wrap((CW+1)'(head) + (CW+1)'(count) - (CW+1)'(1));
  assign wr_addr   = wrap((CW+1)'(head) + (CW+1)'(count));
  assign scan_addr = wrap((CW+1)'(head) + (CW+1)'(idx));
  assign head_inc  = wrap((CW+1)'(head) + (CW+1)'(1));

  // Read address follows the step being taken.
  always_comb begin
    case (state)
      L_CK_T:  rd_addr = tail_old;
      L_SCAN:  rd_addr = scan_addr;
      default: rd_addr = head;
    endcase
  end

  // Memory write and registered read; slot zero reads as zero after a clear.
  always_ff @(posedge clk) begin
    if (state == L_WR) begin
      mem_t[wr_addr] <= now_r;
      mem_v[wr_addr] <= meas_r;
    end
    rd_t    <= mem_t[rd_addr];
    rd_v    <= mem_v[rd_addr];
    rd_zero <= zflag && (rd_addr == '0);
  end

  assign rt = rd_zero ? 32'd0 : rd_t;
  assign rv = rd_zero ? 16'sd0 : rd_v;

  // Aging condition: oldest time plus window below the newest, without wrap.
  assign aged = (count > CW'(1)) &&
                (({1'b0, rt} + {17'd0, win_r}) < {1'b0, t_tail});

  // Limit decision and divider step.
  always_comb begin
    mw      = wal_pkg::mag16(want_r);
    mr      = wal_pkg::mag16(ref_v);
    nolim   = (mw <= mr) || ({(mw - mr), 1'b0} < {2'b00, acc2_r});
    mr2     = ((ref_v == 16'sd0) || (ref_v[15] != want_r[15])) ? 17'd0 : mr;
    target2 = {mr2, 1'b0} + {2'b00, acc2_r};
    sh      = {rem, nlo[15]};
    qbit    = (sh >= {1'b0, dv});
  end

  // Lane sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      head  <= '0;
      count <= CW'(1);
      zflag <= 1'b1;
      sc_v  <= 1'b0;
    end else begin
      sc_v <= (state == L_SCAN);
      // Reference tracking handles each scan address in the cycle after it is issued.
      if (sc_v) begin
        if (ref_first || (wal_pkg::mag16(rv) < wal_pkg::mag16(ref_v))) begin
          ref_v <= rv;
        end
        ref_first <= 1'b0;
      end
      unique case (state)
        L_IDLE: begin
          if (cmd.check) begin
            state <= L_CK_H;
          end
        end
        L_CK_H: state <= L_CK_T;
        L_CK_T: begin
          t_head <= rt;
          state  <= L_CK_E;
        end
        L_CK_E: begin
          t_tail <= rt;
          stale  <= (count > CW'(1)) && (t_head >= rt);
          state  <= L_WAIT;
        end
        L_WAIT: begin
          if (cmd.update) begin
            now_r  <= now;
            meas_r <= meas;
            want_r <= want;
            acc2_r <= acc2;
            win_r  <= win;
            rpost  <= cmd.restart_post;
            if (cmd.restart_pre) begin
              head  <= '0;
              count <= CW'(1);
              zflag <= 1'b1;
              state <= L_FULL;
            end else begin
              state <= L_AG_R;
            end
          end
        end
        L_AG_R: state <= L_AG_C;
        L_AG_C: begin
          if (aged) begin
            head  <= head_inc;
            count <= count - CW'(1);
            state <= L_AG_R;
          end else begin
            state <= L_FULL;
          end
        end
        L_FULL: begin
          if (count >= CW'(WINDOW_DEPTH)) begin
            head  <= head_inc;
            count <= CW'(WINDOW_DEPTH - 1);
          end
          state <= L_WR;
        end
        L_WR: begin
          count <= count + CW'(1);
          if (wr_addr == '0) begin
            zflag <= 1'b0;
          end
          idx       <= '0;
          ref_first <= 1'b1;
          state     <= L_SCAN;
        end
        L_SCAN: begin
          idx <= idx + CW'(1);
          if (idx == count - CW'(1)) begin
            state <= L_SEND;
          end
        end
        L_SEND: state <= L_LIM;
        L_LIM: begin
          if (nolim) begin
            factor <= wal_pkg::ONE_Q15;
            state  <= L_DONE;
          end else begin
            rem   <= target2[17:1];
            nlo   <= {target2[0], 15'd0};
            dv    <= 17'({mw, 1'b0});
            quo   <= '0;
            dcnt  <= '0;
            state <= L_DIV;
          end
        end
        L_DIV: begin
          rem  <= qbit ? 17'(sh - {1'b0, dv}) : sh[16:0];
          nlo  <= {nlo[14:0], 1'b0};
          quo  <= {quo[14:0], qbit};
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'(wal_pkg::DIV_STEPS - 1)) begin
            factor <= {quo[14:0], qbit};
            state  <= L_DONE;
          end
        end
        L_DONE: begin
          if (rpost) begin
            head  <= '0;
            count <= CW'(1);
            zflag <= 1'b1;
          end
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign stat.busy   = (state != L_IDLE) && (state != L_WAIT);
  assign stat.stale  = stale;
  assign stat.factor = factor;

endmodule

[hdl/wal_merge.sv]
// Merging stage of the windowed acceleration limiter.
// Picks the smallest lane factor and scales the desired vector by it.
// Depends on wal_pkg for the result struct and the magnitude helper.
module wal_merge (
  input  logic                clk,
  input  logic                load,
  input  logic         [15:0] fx,
  input  logic         [15:0] fy,
  input  logic         [15:0] fr,
  input  logic signed  [15:0] want_x,
  input  logic signed  [15:0] want_y,
  input  logic signed  [15:0] want_rot,
  output wal_pkg::wal_out_t   res
);

  logic [15:0] f_min;
  logic [15:0] f_xy;

  // Smallest factor, registered before the multipliers.
  assign f_xy = (fy < fx) ? fy : fx;

  always_ff @(posedge clk) begin
    if (load) begin
      f_min <= (fr < f_xy) ? fr : f_xy;
    end
  end

  // Magnitude times factor, truncated toward zero, sign restored.
  function automatic logic signed [15:0] apply(input logic signed [15:0] w,
                                               input logic [15:0] f);
    logic [32:0] p;
    logic [16:0] m;
    p = wal_pkg::mag16(w) * f;
    m = p[31:15];
    apply = w[15] ? 16'(-m) : m[15:0];
  endfunction

  assign res.out_x   = apply(want_x, f_min);
  assign res.out_y   = apply(want_y, f_min);
  assign res.out_rot = apply(want_rot, f_min);
  assign res.scale   = f_min;

endmodule

[hdl/windowed_acceleration_limiter.sv]
// Top level of the windowed acceleration limiter: configuration registers,
// request sequencing, three axis lanes, merge stage and output register.
// Depends on wal_pkg, wal_lane and wal_merge.
//
// Usage:
//   Requests enter on in_valid/in_ready as one wal_in_t; results leave on
//   out_valid/out_ready as one wal_out_t, exactly one result per request.
//   Registers are written on cfg_valid/cfg_ready (cfg_ready is always high)
//   with cfg_index selecting max_acc_x, max_acc_y, max_acc_rot, window_x,
//   window_y or window_rot, and should only be written while the block idles.
//   One request is processed at a time. Each lane runs a staleness check,
//   ages out expired entries one at a time, writes the new entry, scans the
//   held entries for the reference speed, tests the limit, divides out the
//   factor when the axis limits and then finishes; the slowest lane sets the
//   pace, and the merge stage and output register follow. Aging, the scan
//   of one entry per cycle and the divide set how long a request takes.
//   in_ready rises again once the merged result sits in the output register,
//   so a new request can be taken while that result waits for out_ready.
//   If the receiver stalls, the next result is held back until the register
//   frees. Reset clears the configuration registers to zero and every history
//   to a single entry of time zero, speed zero.
module windowed_acceleration_limiter #(
  parameter int WINDOW_DEPTH = wal_pkg::WINDOW_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wal_pkg::wal_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wal_pkg::wal_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic         [2:0] cfg_index,
  input  logic        [15:0] cfg_data
);

  typedef enum logic [2:0] {T_IDLE, T_CHK, T_UPD, T_MIN} top_state_t;

  top_state_t state;

  logic [14:0] max_acc_x, max_acc_y, max_acc_rot;
  logic [15:0] window_x, window_y, window_rot;

  wal_pkg::wal_in_t req;
  wal_pkg::wal_lane_cmd_t  cmd_x, cmd_y, cmd_r;
  wal_pkg::wal_lane_stat_t st_x, st_y, st_r;
  wal_pkg::wal_out_t merge_res;

  logic        accept;
  logic        lanes_free;
  logic        issue_upd;
  logic        merge_load;
  logic        out_load;
  logic [15:0] acc2_x;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state == T_IDLE);
  assign accept     = in_valid && in_ready;
  assign lanes_free = !st_x.busy && !st_y.busy && !st_r.busy;
  assign issue_upd  = (state == T_CHK) && lanes_free;
  assign merge_load = (state == T_UPD) && lanes_free;
  assign out_load   = (state == T_MIN) && (!out_valid || out_ready);

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_acc_x   <= '0;
      max_acc_y   <= '0;
      max_acc_rot <= '0;
      window_x    <= '0;
      window_y    <= '0;
      window_rot  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (wal_pkg::wal_cfg_idx_t'(cfg_index))
        wal_pkg::CFG_MAX_ACC_X:   max_acc_x   <= cfg_data[14:0];
        wal_pkg::CFG_MAX_ACC_Y:   max_acc_y   <= cfg_data[14:0];
        wal_pkg::CFG_MAX_ACC_ROT: max_acc_rot <= cfg_data[14:0];
        wal_pkg::CFG_WINDOW_X:    window_x    <= cfg_data;
        wal_pkg::CFG_WINDOW_Y:    window_y    <= cfg_data;
        wal_pkg::CFG_WINDOW_ROT:  window_rot  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The x step is halved when the robot moves slowly; steps are in doubled units.
  assign acc2_x = (req.current_x > wal_pkg::SLOW_X_RAW) ? {max_acc_x, 1'b0}
                                                        : {1'b0, max_acc_x};

  // A stale axis restarts itself and every later axis from the reset history,
  // and leaves every earlier axis reset once its factor is taken. Once an
  // earlier axis has restarted everything, later axes cannot be stale.
  always_comb begin
    cmd_x = '0;
    cmd_y = '0;
    cmd_r = '0;
    cmd_x.check = accept;
    cmd_y.check = accept;
    cmd_r.check = accept;
    cmd_x.update = issue_upd;
    cmd_y.update = issue_upd;
    cmd_r.update = issue_upd;
    cmd_x.restart_pre  = st_x.stale;
    cmd_y.restart_pre  = st_x.stale || st_y.stale;
    cmd_r.restart_pre  = st_x.stale || st_y.stale || st_r.stale;
    cmd_x.restart_post = !st_x.stale && (st_y.stale || st_r.stale);
    cmd_y.restart_post = !st_x.stale && !st_y.stale && st_r.stale;
    cmd_r.restart_post = 1'b0;
  end

  wal_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane_x (
    .clk(clk), .rst(rst), .cmd(cmd_x), .now(req.tick_time), .meas(req.meas_x),
    .want(req.want_x), .acc2(acc2_x), .win(window_x), .stat(st_x)
  );

  wal_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane_y (
    .clk(clk), .rst(rst), .cmd(cmd_y), .now(req.tick_time), .meas(req.meas_y),
    .want(req.want_y), .acc2({max_acc_y, 1'b0}), .win(window_y), .stat(st_y)
  );

  wal_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane_r (
    .clk(clk), .rst(rst), .cmd(cmd_r), .now(req.tick_time), .meas(req.meas_rot),
    .want(req.want_rot), .acc2({max_acc_rot, 1'b0}), .win(window_rot), .stat(st_r)
  );

  wal_merge u_merge (
    .clk(clk), .load(merge_load), .fx(st_x.factor), .fy(st_y.factor),
    .fr(st_r.factor), .want_x(req.want_x), .want_y(req.want_y),
    .want_rot(req.want_rot), .res(merge_res)
  );

  // Request sequencing and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_data  <= merge_res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            req   <= in_data;
            state <= T_CHK;
          end
        end
        T_CHK: begin
          if (issue_upd) begin
            state <= T_UPD;
          end
        end
        T_UPD: begin
          if (merge_load) begin
            state <= T_MIN;
          end
        end
        T_MIN: begin
          if (out_load) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // The applied factor never exceeds one.
  a_scale_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.scale <= wal_pkg::ONE_Q15))
    else $error("scale above one");

  // After a request is taken no other is taken until its result is loaded.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second request taken while one is in flight");

  // A result is loaded only after the lanes have all finished.
  a_load_after_lanes: assert property (@(posedge clk) disable iff (rst)
    out_load |-> lanes_free)
    else $error("result loaded while a lane is busy");

endmodule
